// ----- rtl/supi_pkg.sv -----
// shared types, status codes and point ordering for the sorted unique point insert block
// no dependencies; used by supi_cell, supi_tree and sorted_unique_point_insert_core
`default_nettype none

package supi_pkg;

    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } point_t;

    typedef struct packed {
        logic bnd;
        logic dup;
    } cell_flag_t;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    function automatic logic point_less(input point_t a, input point_t b);
        logic res;
        begin
            if (a.x != b.x)
            begin
                res = (a.x < b.x);
            end
            else if (a.y != b.y)
            begin
                res = (a.y < b.y);
            end
            else
            begin
                res = (a.z < b.z);
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/supi_cell.sv -----
// one table slot: holds a stored point, compares it with the broadcast key
// and takes the key or its left neighbor's point on insert; depends on supi_pkg
`default_nettype none

module supi_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 9
) (
    input  wire                     clk,
    input  wire                     cmp_en,
    input  wire                     commit,
    input  supi_pkg::point_t        key,
    input  wire [CNT_W-1:0]         count,
    input  supi_pkg::point_t        left_entry,
    input  wire                     left_lt,
    output supi_pkg::point_t        entry,
    output logic                    lt,
    output supi_pkg::cell_flag_t    flag
);

    supi_pkg::point_t entry_reg;
    logic             lt_reg;
    logic             eq_reg;
    logic             slot_valid;
    logic             lt_next;
    logic             eq_next;

    assign slot_valid = (count > CNT_W'(IDX));
    assign lt_next    = slot_valid && supi_pkg::point_less(entry_reg, key);
    assign eq_next    = slot_valid && (entry_reg == key);

    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
        if (commit && !lt_reg)
        begin
            entry_reg <= left_lt ? key : left_entry;
        end
    end

    assign entry    = entry_reg;
    assign lt       = lt_reg;
    assign flag.bnd = !lt_reg && left_lt;
    assign flag.dup = eq_reg;

endmodule

`default_nettype wire

// ----- rtl/supi_tree.sv -----
// registered binary or-tree that gathers the insert index and the duplicate flag
// from all cells, one level per cycle; depends on supi_pkg
`default_nettype none

module supi_tree #(
    parameter int N     = 256,
    parameter int IDX_W = 8
) (
    input  wire                     clk,
    input  supi_pkg::cell_flag_t    flags [N],
    output logic [IDX_W-1:0]        pos,
    output logic                    dup
);

    localparam int P = 1 << IDX_W;

    logic [IDX_W-1:0] leaf_pos [P];
    logic             leaf_dup [P];
    logic [IDX_W-1:0] node_pos_reg [1:P-1];
    logic             node_dup_reg [1:P-1];

    genvar j, k;

    generate
        for (j = 0; j < P; j++)
        begin : g_leaf
            if (j < N)
            begin : g_used
                assign leaf_pos[j] = flags[j].bnd ? IDX_W'(j) : '0;
                assign leaf_dup[j] = flags[j].dup;
            end
            else
            begin : g_pad
                assign leaf_pos[j] = '0;
                assign leaf_dup[j] = 1'b0;
            end
        end

        for (k = 1; k < P; k++)
        begin : g_node
            if (2 * k >= P)
            begin : g_bottom
                always_ff @(posedge clk)
                begin
                    node_pos_reg[k] <= leaf_pos[2*k-P] | leaf_pos[2*k+1-P];
                    node_dup_reg[k] <= leaf_dup[2*k-P] | leaf_dup[2*k+1-P];
                end
            end
            else
            begin : g_inner
                always_ff @(posedge clk)
                begin
                    node_pos_reg[k] <= node_pos_reg[2*k] | node_pos_reg[2*k+1];
                    node_dup_reg[k] <= node_dup_reg[2*k] | node_dup_reg[2*k+1];
                end
            end
        end
    endgenerate

    assign pos = node_pos_reg[1];
    assign dup = node_dup_reg[1];

endmodule

`default_nettype wire

// ----- rtl/sorted_unique_point_insert_core.sv -----
// top level of the sorted unique point insert block: control, cell chain and result register
// depends on supi_pkg, supi_cell and supi_tree
//
// usage:
//   s_tdata carries one point a beat; the block keeps up to TABLE_DEPTH distinct
//   points in ascending order of x, then y, then z (signed Q16.16)
//   m_tdata returns one result beat for every input beat: status, sorted position
//   and the number of points stored after that beat
//   each point is compared in all cells at once, then the insert index and the
//   duplicate flag climb a registered or-tree of clog2(TABLE_DEPTH) levels
//   the result reaches the output register once the flags have climbed that tree,
//   and the block takes no new point before it is through with the last one
//   the next point is taken while a result still waits in the output register
//   if the receiver stalls, the block holds in its final step until the output
//   register is free, and then writes the cells
//   reset empties the table (count to zero) and drops any pending result
`default_nettype none

module sorted_unique_point_insert_core #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [95:0]  s_tdata,    // x_coord[31:0], y_coord[63:32], z_coord[95:64]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata     // status[1:0], position[9:2], stored_count[18:10], zero pad
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WAIT_W = $clog2(IDX_W + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_TREE = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [WAIT_W-1:0] wait_reg;
    logic [WAIT_W-1:0] wait_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    supi_pkg::point_t  key_reg;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [23:0]       m_tdata_reg;
    logic [23:0]       m_tdata_next;

    supi_pkg::point_t     entries [TABLE_DEPTH];
    logic                 lts     [TABLE_DEPTH];
    supi_pkg::cell_flag_t flags   [TABLE_DEPTH];

    logic             cmp_en;
    logic             commit;
    logic             out_free;
    logic             finish;
    logic             full;
    logic [IDX_W-1:0] tree_pos;
    logic             tree_dup;
    logic [1:0]       status;
    logic [31:0]      pos_wide;
    logic [31:0]      cnt_wide;

    genvar i;

    generate
        for (i = 0; i < TABLE_DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                supi_cell #(
                    .IDX   (i),
                    .CNT_W (CNT_W)
                ) u_cell (
                    .clk        (clk),
                    .cmp_en     (cmp_en),
                    .commit     (commit),
                    .key        (key_reg),
                    .count      (count_reg),
                    .left_entry (key_reg),
                    .left_lt    (1'b1),
                    .entry      (entries[i]),
                    .lt         (lts[i]),
                    .flag       (flags[i])
                );
            end
            else
            begin : g_rest
                supi_cell #(
                    .IDX   (i),
                    .CNT_W (CNT_W)
                ) u_cell (
                    .clk        (clk),
                    .cmp_en     (cmp_en),
                    .commit     (commit),
                    .key        (key_reg),
                    .count      (count_reg),
                    .left_entry (entries[i-1]),
                    .left_lt    (lts[i-1]),
                    .entry      (entries[i]),
                    .lt         (lts[i]),
                    .flag       (flags[i])
                );
            end
        end
    endgenerate

    supi_tree #(
        .N     (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_tree (
        .clk   (clk),
        .flags (flags),
        .pos   (tree_pos),
        .dup   (tree_dup)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign cmp_en   = (state_reg == S_CMP);
    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == S_DONE) && out_free;
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));
    assign commit   = finish && !tree_dup && !full;

    always_comb
    begin
        if (tree_dup)
        begin
            status = supi_pkg::ST_DUPLICATE;
        end
        else if (full)
        begin
            status = supi_pkg::ST_FULL;
        end
        else
        begin
            status = supi_pkg::ST_INSERTED;
        end
    end

    always_comb
    begin
        pos_wide   = (!tree_dup && full) ? 32'd0 : 32'(tree_pos);
        count_next = commit ? CNT_W'(count_reg + 1'b1) : count_reg;
        cnt_wide   = 32'(count_next);
    end

    always_comb
    begin
        state_next    = state_reg;
        wait_next     = wait_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_TREE;
                wait_next  = '0;
            end
            S_TREE:
            begin
                if (wait_reg == WAIT_W'(IDX_W - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wait_next = WAIT_W'(wait_reg + 1'b1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, cnt_wide[8:0], pos_wide[7:0], status};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            wait_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wait_reg     <= wait_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            key_reg <= s_tdata;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("stored count beyond table depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("insert did not advance the count");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == supi_pkg::ST_INSERTED
                   || m_tdata[1:0] == supi_pkg::ST_DUPLICATE
                   || m_tdata[1:0] == supi_pkg::ST_FULL))
        else $error("result beat with unknown status");

    a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_CMP))
        else $error("accepted beat did not start a compare");

    a_full_no_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && full && !tree_dup) |=> (m_tdata[1:0] == supi_pkg::ST_FULL
                                         && m_tdata[9:2] == 8'd0))
        else $error("full table result malformed");

endmodule

`default_nettype wire
